>>> hdl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants of the ordered list engine
// Store geometry, request and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 9;

  typedef logic [OP_W-1:0]          op_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam op_t OP_INSERT   = 3'd0;
  localparam op_t OP_APPEND   = 3'd1;
  localparam op_t OP_GET      = 3'd2;
  localparam op_t OP_CONTAINS = 3'd3;
  localparam op_t OP_REMOVE   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PTR_POS,
    PTR_CNT,
    PTR_ZERO
  } ptr_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_UP,
    S_GET,
    S_RM_CAP,
    S_DOWN,
    S_SCAN,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic     load;
    logic     init_ptr;
    ptr_sel_e ptr_sel;
    logic     up_step;
    logic     down_step;
    logic     scan_step;
    logic     rd_pos;
    logic     cap_rd;
    logic     set_status;
    status_e  status;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic cnt_zero;
    logic cnt_full;
    logic up_done;
    logic down_done;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/ole_if.sv
// ----------------------------------------------------------------------------
// ole_if: request and result channels of the ordered list engine
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ole_req_if;
  logic                          valid;
  logic                          ready;
  logic [ole_pkg::OP_W-1:0]      operation;
  logic [ole_pkg::POS_W-1:0]     position;
  logic signed [ole_pkg::DATA_W-1:0] data_value;

  modport source (output valid, output operation, output position, output data_value,
                  input ready);
  modport sink   (input valid, input operation, input position, input data_value,
                  output ready);
endinterface

interface ole_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [ole_pkg::DATA_W-1:0] read_value;
  logic                              found;
  logic [ole_pkg::CNT_W-1:0]         entry_count;
  logic                              is_empty;

  modport source (output valid, output status, output read_value, output found,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input read_value, input found,
                  input entry_count, input is_empty, output ready);
endinterface

>>> hdl/ole_dpath.sv
// ----------------------------------------------------------------------------
// ole_dpath: list store, element count, walk pointer and result register
// Executes one shift, scan or read step per cycle as commanded.
// ----------------------------------------------------------------------------
module ole_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ole_pkg::cmd_t             cmd_i,
  output ole_pkg::sts_t             sts_o,
  input  ole_pkg::op_t              op_i,
  input  ole_pkg::pos_t             pos_i,
  input  ole_pkg::data_t            val_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [1:0]                out_status_o,
  output ole_pkg::data_t            out_read_value_o,
  output logic                      out_found_o,
  output ole_pkg::cnt_t             out_entry_count_o,
  output logic                      out_is_empty_o
);
  import ole_pkg::*;

  data_t   list_mem [DEPTH];
  data_t   rdata_q;

  op_t     op_q;
  cnt_t    pos_q;
  data_t   val_q;
  cnt_t    count_q;
  cnt_t    ptr_q;
  cnt_t    wr_addr_q;
  logic    pend_q;
  status_e status_q;
  data_t   rd_val_q;
  logic    found_q;

  logic    out_valid_q;
  status_e out_status_q;
  data_t   out_rd_q;
  logic    out_found_q;
  cnt_t    out_cnt_q;
  logic    out_empty_q;

  cnt_t    ptr_inc;
  cnt_t    ptr_dec;
  logic    ptr_gt_pos;
  logic    ptr_lt_cnt;
  logic    dn_more;

  logic    we;
  cnt_t    waddr;
  data_t   wdata;
  logic    re;
  cnt_t    raddr;

  assign ptr_inc    = ptr_q + cnt_t'(1);
  assign ptr_dec    = ptr_q - cnt_t'(1);
  assign ptr_gt_pos = ptr_q > pos_q;
  assign ptr_lt_cnt = ptr_q < count_q;
  assign dn_more    = ptr_inc < count_q;

  // one write port, one read port; pending write lands the step after its read
  always_comb begin
    we    = 1'b0;
    waddr = wr_addr_q;
    wdata = rdata_q;
    re    = 1'b0;
    raddr = pos_q;
    if (cmd_i.rd_pos) begin
      re = 1'b1;
    end
    if (cmd_i.up_step) begin
      if (pend_q) begin
        we = 1'b1;
      end else if (!ptr_gt_pos) begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = val_q;
      end
      if (ptr_gt_pos) begin
        re    = 1'b1;
        raddr = ptr_dec;
      end
    end
    if (cmd_i.down_step) begin
      if (pend_q) begin
        we = 1'b1;
      end
      if (dn_more) begin
        re    = 1'b1;
        raddr = ptr_inc;
      end
    end
    if (cmd_i.scan_step && ptr_lt_cnt) begin
      re    = 1'b1;
      raddr = ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      list_mem[waddr[ADDR_W-1:0]] <= wdata;
    end
    if (re) begin
      rdata_q <= list_mem[raddr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + cnt_t'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - cnt_t'(1);
      end
      if (cmd_i.init_ptr) begin
        pend_q <= 1'b0;
      end else if (cmd_i.up_step) begin
        pend_q <= ptr_gt_pos;
      end else if (cmd_i.down_step) begin
        pend_q <= dn_more;
      end else if (cmd_i.scan_step) begin
        pend_q <= ptr_lt_cnt;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      pos_q    <= (op_i == OP_APPEND) ? count_q : cnt_t'(pos_i);
      val_q    <= val_i;
      status_q <= ST_OK;
      rd_val_q <= '0;
      found_q  <= 1'b0;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.cap_rd) begin
      rd_val_q <= rdata_q;
    end
    if (cmd_i.init_ptr) begin
      case (cmd_i.ptr_sel)
        PTR_POS: ptr_q <= pos_q;
        PTR_CNT: ptr_q <= count_q;
        default: ptr_q <= '0;
      endcase
    end else if (cmd_i.up_step) begin
      if (ptr_gt_pos) begin
        ptr_q     <= ptr_dec;
        wr_addr_q <= ptr_q;
      end
    end else if (cmd_i.down_step) begin
      if (dn_more) begin
        ptr_q     <= ptr_inc;
        wr_addr_q <= ptr_q;
      end
    end else if (cmd_i.scan_step) begin
      if (pend_q && (rdata_q == val_q)) begin
        found_q <= 1'b1;
      end
      if (ptr_lt_cnt) begin
        ptr_q <= ptr_inc;
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_rd_q     <= rd_val_q;
      out_found_q  <= found_q;
      out_cnt_q    <= count_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  always_comb begin
    sts_o.op         = op_q;
    sts_o.pos_gt_cnt = pos_q > count_q;
    sts_o.pos_ge_cnt = pos_q >= count_q;
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.cnt_full   = (count_q == cnt_t'(DEPTH));
    sts_o.up_done    = !ptr_gt_pos && !pend_q;
    sts_o.down_done  = !dn_more && !pend_q;
    sts_o.scan_done  = found_q || (!ptr_lt_cnt && !pend_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_read_value_o  = out_rd_q;
  assign out_found_o       = out_found_q;
  assign out_entry_count_o = out_cnt_q;
  assign out_is_empty_o    = out_empty_q;

  // count never passes the store size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(DEPTH))
    else $error("entry count above store depth");

  // reads only touch live entries
  a_read_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> (raddr < count_q))
    else $error("read beyond the list end");

  // shifts never write past the slot just after the list end
  a_write_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (waddr <= count_q))
    else $error("write beyond the list end");

  a_cnt_one_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> !cmd_i.cnt_dec)
    else $error("count incremented and decremented together");

endmodule

>>> hdl/ole_ctrl.sv
// ----------------------------------------------------------------------------
// ole_ctrl: request sequencer of the ordered list engine
// Checks bounds, runs the shift walk, scan walk or single read, then hands off the result.
// ----------------------------------------------------------------------------
module ole_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ole_pkg::sts_t sts_i,
  output ole_pkg::cmd_t cmd_o
);
  import ole_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.status  = ST_OK;
    cmd_o.ptr_sel = PTR_POS;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_DONE;
        case (sts_i.op) inside
          OP_INSERT, OP_APPEND: begin
            if ((sts_i.op == OP_INSERT) && sts_i.pos_gt_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else if (sts_i.cnt_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.init_ptr = 1'b1;
              cmd_o.ptr_sel  = PTR_CNT;
              state_d        = S_UP;
            end
          end
          OP_GET: begin
            if (sts_i.pos_ge_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else begin
              cmd_o.rd_pos = 1'b1;
              state_d      = S_GET;
            end
          end
          OP_CONTAINS: begin
            cmd_o.init_ptr = 1'b1;
            cmd_o.ptr_sel  = PTR_ZERO;
            state_d        = S_SCAN;
          end
          OP_REMOVE: begin
            if (sts_i.cnt_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
            end else if (sts_i.pos_ge_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else begin
              cmd_o.rd_pos   = 1'b1;
              cmd_o.init_ptr = 1'b1;
              cmd_o.ptr_sel  = PTR_POS;
              state_d        = S_RM_CAP;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_UP: begin
        cmd_o.up_step = 1'b1;
        if (sts_i.up_done) begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_GET: begin
        cmd_o.cap_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_RM_CAP: begin
        cmd_o.cap_rd = 1'b1;
        state_d      = S_DOWN;
      end
      S_DOWN: begin
        cmd_o.down_step = 1'b1;
        if (sts_i.down_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hdl/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit: ordered list of signed 32-bit values
//
//   channel  dir  payload                                         moves on
//   req_i    in   operation, position, data_value                 valid && ready
//   rsp_o    out  status, read_value, found, entry_count, is_empty valid && ready
//
// One request at a time. Get reads one entry; errors and unknown codes go
// straight to the result. Insert/append shift the entries from position up
// to the list end; remove shifts those above position down; contains scans
// from the start until a match or the list end; the single read and single
// write port of the list store moves one entry per cycle.
// Reset clears the sequencer state, the count, the pending-write flag and the result valid only;
// the store needs no clearing pass. A finished result waits in the output
// register while the next request is taken; a stalled result holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ole_req_if.sink   req_i,
  ole_rsp_if.source rsp_o
);
  import ole_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ole_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ole_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .op_i              (req_i.operation),
    .pos_i             (req_i.position),
    .val_i             (req_i.data_value),
    .out_ready_i       (rsp_o.ready),
    .out_valid_o       (rsp_o.valid),
    .out_status_o      (rsp_o.status),
    .out_read_value_o  (rsp_o.read_value),
    .out_found_o       (rsp_o.found),
    .out_entry_count_o (rsp_o.entry_count),
    .out_is_empty_o    (rsp_o.is_empty)
  );

endmodule

>>> sim/ordered_list_engine_unit_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_unit_scoreboard: result checker for the list engine
// Watches both channels. Every accepted request updates a shadow copy of the
// list and queues the result it must produce. Every accepted result is
// compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit_scoreboard (
  input  logic          clk_i,
  input  logic          rst_ni,
  ole_req_if            req_mon_i,
  ole_rsp_if            rsp_mon_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o,
  output ole_pkg::cnt_t list_count_o
);
  import ole_pkg::*;

  typedef struct packed {
    status_e status;
    data_t   read_value;
    logic    found;
    cnt_t    entry_count;
    logic    is_empty;
  } list_result_t;

  data_t        shadow_list [DEPTH];
  int unsigned  shadow_count;
  list_result_t queued_results [$];

  // shift entries at and above pos up by one, then write
  function automatic void place_entry(int unsigned pos, data_t val);
    for (int unsigned i = shadow_count; i > pos; i--) begin
      shadow_list[i] = shadow_list[i - 1];
    end
    shadow_list[pos] = val;
    shadow_count++;
  endfunction

  function automatic list_result_t apply_request(op_t op, pos_t pos, data_t val);
    list_result_t r;
    int unsigned  p;
    p = pos;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        // range is checked before full
        if (p > shadow_count) r.status = ST_RANGE;
        else if (shadow_count >= DEPTH) r.status = ST_FULL;
        else place_entry(p, val);
      end
      OP_APPEND: begin
        if (shadow_count >= DEPTH) r.status = ST_FULL;
        else place_entry(shadow_count, val);
      end
      OP_GET: begin
        if (p >= shadow_count) r.status = ST_RANGE;
        else r.read_value = shadow_list[p];
      end
      OP_CONTAINS: begin
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] == val) begin
            r.found = 1'b1;
            break;
          end
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (p >= shadow_count) r.status = ST_RANGE;
        else begin
          r.read_value = shadow_list[p];
          for (int unsigned i = p; i + 1 < shadow_count; i++) begin
            shadow_list[i] = shadow_list[i + 1];
          end
          shadow_count--;
        end
      end
      default: ;  // unused codes leave the list alone
    endcase
    r.entry_count = cnt_t'(shadow_count);
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  function automatic void compare_field(string field, logic signed [DATA_W-1:0] want,
                                        logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_result_t oldest;
    if (!rst_ni) begin
      shadow_count = 0;
      queued_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      list_count_o = '0;
    end else begin
      // a result accepted here belongs to an earlier request
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (queued_results.size() == 0) begin
          $error("result with no request outstanding: status %0d count %0d",
                 rsp_mon_i.status, rsp_mon_i.entry_count);
          fail_count_o++;
        end else begin
          oldest = queued_results.pop_front();
          compare_field("status", oldest.status, rsp_mon_i.status);
          compare_field("read_value", oldest.read_value, rsp_mon_i.read_value);
          compare_field("found", oldest.found, rsp_mon_i.found);
          compare_field("entry_count", oldest.entry_count, rsp_mon_i.entry_count);
          compare_field("is_empty", oldest.is_empty, rsp_mon_i.is_empty);
        end
      end
      if (req_mon_i.valid && req_mon_i.ready) begin
        queued_results.push_back(apply_request(req_mon_i.operation, req_mon_i.position,
                                               req_mon_i.data_value));
      end
      pending_o    = queued_results.size();
      list_count_o = cnt_t'(shadow_count);
    end
  end

endmodule

>>> sim/ordered_list_engine_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_unit_test: testbench top for the ordered list engine
// Drives directed corner requests, a fill to capacity and a drain, then
// random request mixes under three idle settings, with a long result stall.
// The scoreboard beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit_test;
  import ole_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 3_000_000;
  localparam int unsigned TAIL_CYCLES    = DEPTH + 16;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned RAND_PER_PHASE = 420;
  localparam int unsigned RECENT_MAX     = 32;
  localparam data_t       DATA_MIN       = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t       DATA_MAX       = {1'b0, {(DATA_W-1){1'b1}}};
  localparam pos_t        POS_MAX        = '1;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_request;
  int unsigned fail_count;
  int unsigned pending;
  cnt_t        list_count;
  data_t       recent_values [$];

  ole_req_if req_ch ();
  ole_rsp_if rsp_ch ();

  ordered_list_engine_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  ordered_list_engine_unit_scoreboard scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_mon_i    (req_ch),
    .rsp_mon_i    (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_count_o (list_count)
  );

  always #5 clk = ~clk;

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input op_t op, input pos_t pos, input data_t val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.position   <= pos;
    req_ch.data_value <= val;
    if (op == OP_INSERT || op == OP_APPEND) begin
      recent_values.push_back(val);
      if (recent_values.size() > RECENT_MAX) void'(recent_values.pop_front());
    end
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic data_t rand_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) return data_t'(int'($urandom_range(6)) - 3);
    if (pick < 35 && recent_values.size() != 0)
      return recent_values[$urandom_range(recent_values.size() - 1)];
    return data_t'($urandom);
  endfunction

  // mostly in-range requests; the list size hovers in the tens
  task automatic send_random_item();
    int unsigned cnt;
    int unsigned grow;
    int unsigned roll;
    int unsigned share;
    data_t       probe;
    cnt   = list_count;
    grow  = (cnt < 8) ? 60 : (cnt > 40) ? 20 : 40;
    share = (100 - grow) / 3;
    roll  = $urandom_range(99);
    if (roll < 8) begin
      send_req(op_t'($urandom_range(7)), pos_t'($urandom), data_t'($urandom));
    end else begin
      roll = $urandom_range(99);
      if (roll < grow) begin
        if ($urandom_range(1)) send_req(OP_INSERT, pos_t'($urandom_range(cnt)), rand_value());
        else send_req(OP_APPEND, pos_t'($urandom), rand_value());
      end else if (roll < grow + share) begin
        send_req(OP_GET, pos_t'((cnt == 0) ? 0 : $urandom_range(cnt - 1)), data_t'($urandom));
      end else if (roll < grow + 2 * share) begin
        probe = (recent_values.size() != 0 && $urandom_range(1)) ?
                recent_values[$urandom_range(recent_values.size() - 1)] : rand_value();
        send_req(OP_CONTAINS, pos_t'($urandom), probe);
      end else begin
        send_req(OP_REMOVE, pos_t'((cnt == 0) ? 0 : $urandom_range(cnt - 1)),
                 data_t'($urandom));
      end
    end
  endtask

  // result side; a hold request forces a long stall counted here
  initial begin : rsp_drive
    int unsigned hold_left;
    logic        hold_seen;
    hold_left    = 0;
    hold_seen    = 1'b0;
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_seen) begin
        hold_left = HOLD_CYCLES;
      end
      hold_seen = hold_request;
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ordered_list_engine_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_INSERT;
    req_ch.position   = '0;
    req_ch.data_value = '0;
    hold_request      = 1'b0;
    send_idle_pct     = 25;
    recv_idle_pct     = 87;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list corners
    send_req(OP_GET, 0, 0);
    send_req(OP_REMOVE, 0, 0);
    send_req(OP_CONTAINS, 0, 0);
    send_req(OP_INSERT, 1, 5);
    // value extremes, insert in the middle and at the end
    send_req(OP_INSERT, 0, DATA_MIN);
    send_req(OP_APPEND, 0, DATA_MAX);
    send_req(OP_APPEND, POS_MAX, 0);
    send_req(OP_INSERT, 1, -1);
    send_req(OP_INSERT, 4, 32'h5555_5555);
    send_req(OP_INSERT, 6, 1);
    send_req(OP_GET, 4, 0);
    send_req(OP_GET, 5, 0);
    send_req(OP_GET, POS_MAX, 0);
    send_req(OP_CONTAINS, 0, -1);
    send_req(OP_CONTAINS, POS_MAX, 12345);
    send_req(OP_REMOVE, 5, 0);
    send_req(OP_REMOVE, POS_MAX, 0);
    send_req(OP_REMOVE, 4, 0);
    send_req(OP_REMOVE, 0, 0);
    for (int c = int'(OP_REMOVE) + 1; c < (1 << OP_W); c++) begin
      send_req(op_t'(c), pos_t'($urandom), data_t'($urandom));
    end
    quiesce();

    // fill to capacity, then the full-list cases
    while (list_count < DEPTH) send_req(OP_APPEND, pos_t'($urandom), rand_value());
    send_req(OP_APPEND, 0, 7);
    send_req(OP_INSERT, 0, 7);
    send_req(OP_INSERT, pos_t'(DEPTH), 7);
    send_req(OP_INSERT, pos_t'(DEPTH + 1), 7);
    send_req(OP_GET, pos_t'(DEPTH - 1), 0);
    send_req(OP_CONTAINS, 0, recent_values[recent_values.size() - 1]);
    send_req(OP_CONTAINS, 0, data_t'($urandom));
    send_req(OP_REMOVE, pos_t'(DEPTH), 0);
    send_req(OP_REMOVE, 0, 0);
    send_req(OP_INSERT, 0, DATA_MIN);
    while (list_count > 0) send_req(OP_REMOVE, pos_t'($urandom_range(list_count - 1)), 0);
    quiesce();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 25; recv_idle_pct = 87; end
        1: begin send_idle_pct = 87; recv_idle_pct = 25; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // long result stall while requests keep coming
          hold_request  = 1'b1;
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_random_item();
        if ($urandom_range(199) == 0) quiesce();
      end
      quiesce();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("ordered_list_engine_unit: match");
    end else begin
      $display("ordered_list_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
